// File: src/scr_pkg.sv
package scr_pkg;

  localparam int N_MAX_DEF = 1024;
  localparam int R_MAX_DEF = 4;

  localparam int R_W    = 3;
  localparam int N_CW   = 11;
  localparam int CFG_DW = 11;

  localparam logic CFG_R = 1'b0;
  localparam logic CFG_N = 1'b1;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] sstate_t;

  typedef struct packed {
    logic       rd_en;
    logic [5:0] rd_idx;
    logic       wr_en;
    logic       wr_in;
    logic       wr_other;
    logic [5:0] wr_idx;
    logic       s_ld;
    logic       s_xor;
    logic       v_mix;
    logic [2:0] s_k;
    logic       v_re;
    logic       v_we;
    logic [5:0] v_off;
    logic       sal_init;
    logic       sal_rnd;
    logic       sal_odd;
    logic       sal_fin;
    logic       base_ld;
    logic       base_mod;
    logic       mod_ld;
    logic       mod_step;
    logic       swap;
    logic       em_issue;
    logic       em_last;
  } cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic out_full;
    logic skid_full;
  } stat_t;

  // quarter-round index sets: column round, then row round
  localparam logic [3:0] QIDX [2][4][4] = '{
    '{'{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd5, 4'd9, 4'd13, 4'd1},
      '{4'd10, 4'd14, 4'd2, 4'd6}, '{4'd15, 4'd3, 4'd7, 4'd11}},
    '{'{4'd0, 4'd1, 4'd2, 4'd3}, '{4'd5, 4'd6, 4'd7, 4'd4},
      '{4'd10, 4'd11, 4'd8, 4'd9}, '{4'd15, 4'd12, 4'd13, 4'd14}}
  };

  function automatic word_t rotl(input word_t v, input int k);
    return (v << k) | (v >> (32 - k));
  endfunction

  function automatic logic [3:0][31:0] quarter(input word_t a, input word_t b,
                                               input word_t c, input word_t d);
    word_t a2, b2, c2, d2;
    b2 = b ^ rotl(a + d, 7);
    c2 = c ^ rotl(b2 + a, 9);
    d2 = d ^ rotl(c2 + b2, 13);
    a2 = a ^ rotl(d2 + c2, 18);
    return {d2, c2, b2, a2};
  endfunction

  function automatic sstate_t half_round(input sstate_t x, input logic odd);
    sstate_t y;
    logic [3:0][31:0] q;
    y = x;
    for (int g = 0; g < 4; g++) begin
      q = quarter(x[QIDX[odd][g][0]], x[QIDX[odd][g][1]],
                  x[QIDX[odd][g][2]], x[QIDX[odd][g][3]]);
      y[QIDX[odd][g][0]] = q[0];
      y[QIDX[odd][g][1]] = q[1];
      y[QIDX[odd][g][2]] = q[2];
      y[QIDX[odd][g][3]] = q[3];
    end
    return y;
  endfunction

endpackage

// File: src/scrypt_romix_top.sv
// scrypt ROMix with a Salsa20/8 BlockMix core. Load a block as 16*r requests of two
// little-endian words, one per cycle; the result block leaves as 16*r requests, one per
// cycle while out_stall_i is low, out_last_o on the final one. Between them the mixing
// runs on one shared Salsa20/8 unit doing one half-round per cycle: each sub-block is an
// 8-item read, the Salsa steps and an 8-item write, and a second-pass round adds the
// Integerify read and the bit-serial mod N. Input is taken only while the block is
// loading; config writes drop a partly loaded block.
module scrypt_romix_top import scr_pkg::*; #(
  parameter int N_MAX = N_MAX_DEF,
  parameter int R_MAX = R_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [63:0]       in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [63:0]       out_data_o,
  output logic              out_last_o
);

  localparam int NW = $clog2(N_MAX + 1);

  logic [R_W-1:0]  r_q;
  logic [N_CW-1:0] n_q;
  logic [R_W-1:0]  r_eff;
  logic [NW-1:0]   n_eff;
  logic [31:0]     r_tmp, n_tmp;
  logic [NW-1:0]   round;
  cmd_t            cmd;
  stat_t           dstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= R_W'(1);
      n_q <= N_CW'(1024);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_R:   r_q <= cfg_data_i[R_W-1:0];
        CFG_N:   n_q <= cfg_data_i[N_CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (r_q == '0) begin
      r_tmp = 32'd1;
    end else if (32'(r_q) > 32'(R_MAX)) begin
      r_tmp = 32'(R_MAX);
    end else begin
      r_tmp = 32'(r_q);
    end
    if (n_q == '0) begin
      n_tmp = 32'd1;
    end else if (32'(n_q) > 32'(N_MAX)) begin
      n_tmp = 32'(N_MAX);
    end else begin
      n_tmp = 32'(n_q);
    end
    r_eff = r_tmp[R_W-1:0];
    n_eff = n_tmp[NW-1:0];
  end

  scr_ctrl #(.N_MAX(N_MAX)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_clr_i  (cfg_we_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .r_i        (r_eff),
    .n_i        (n_eff),
    .stat_i     (dstat),
    .cmd_o      (cmd),
    .round_o    (round)
  );

  scr_dp #(.N_MAX(N_MAX), .R_MAX(R_MAX)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .round_i     (round),
    .r_i         (r_eff),
    .n_i         (n_eff),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .out_last_o  (out_last_o),
    .stat_o      (dstat)
  );

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstat.skid_full |-> dstat.out_full)
    else $error("skid stage holds a request while output register is empty");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_last_o) |=> !(out_valid_o && out_last_o))
    else $error("two last requests back to back");

  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.em_issue |-> in_stall_o)
    else $error("input accepted while result block is being read out");

endmodule

// File: src/scr_ctrl.sv
module scr_ctrl import scr_pkg::*; #(
  parameter int N_MAX = N_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_clr_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [R_W-1:0]               r_i,
  input  logic [$clog2(N_MAX+1)-1:0]   n_i,
  input  stat_t                        stat_i,
  output cmd_t                         cmd_o,
  output logic [$clog2(N_MAX+1)-1:0]   round_o
);

  localparam int NW = $clog2(N_MAX + 1);

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_INIT  = 8'b0000_0010,
    ST_SUBRD = 8'b0000_0100,
    ST_SALSA = 8'b0000_1000,
    ST_WR    = 8'b0001_0000,
    ST_JRD   = 8'b0010_0000,
    ST_MOD   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [2:0]    sub_q, sub_d;
  logic [NW-1:0] round_q, round_d;
  logic          pass_q, pass_d;
  logic [6:0]    load_q, load_d;

  logic [6:0] items;
  logic [3:0] two_r;
  logic [2:0] last_sub;
  logic [2:0] pos;
  logic [2:0] kprev;

  assign items    = {r_i, 4'b0000};
  assign two_r    = {r_i, 1'b0};
  assign last_sub = 3'(two_r - 4'd1);
  assign pos      = sub_q[0] ? 3'(r_i + {1'b0, sub_q[2:1]}) : {1'b0, sub_q[2:1]};
  assign kprev    = 3'(cnt_q[2:0] - 3'd1);

  assign in_stall_o = (state_q != ST_LOAD);
  assign round_o    = round_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sub_d   = sub_q;
    round_d = round_q;
    pass_d  = pass_q;
    load_d  = load_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_in  = 1'b1;
          cmd_o.wr_idx = load_q[5:0];
          if (7'(load_q + 7'd1) == items) begin
            load_d  = '0;
            state_d = ST_INIT;
            pass_d  = 1'b0;
            round_d = '0;
            cnt_d   = '0;
          end else begin
            load_d = 7'(load_q + 7'd1);
          end
        end
      end
      ST_INIT: begin
        if (cnt_q < 7'd8) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = {last_sub, cnt_q[2:0]};
          cmd_o.v_re   = pass_q;
          cmd_o.v_off  = {last_sub, cnt_q[2:0]};
        end
        if (cnt_q != 7'd0) begin
          cmd_o.s_ld  = 1'b1;
          cmd_o.v_mix = pass_q;
          cmd_o.s_k   = kprev;
        end
        if (cnt_q == 7'd0 && !pass_q) begin
          cmd_o.base_ld = 1'b1;
        end
        if (cnt_q == 7'd8) begin
          state_d = ST_SUBRD;
          sub_d   = '0;
          cnt_d   = '0;
        end else begin
          cnt_d = 7'(cnt_q + 7'd1);
        end
      end
      ST_SUBRD: begin
        if (cnt_q < 7'd8) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = {sub_q, cnt_q[2:0]};
          cmd_o.v_re   = pass_q;
          cmd_o.v_off  = {sub_q, cnt_q[2:0]};
        end
        if (cnt_q != 7'd0) begin
          cmd_o.s_ld  = 1'b1;
          cmd_o.s_xor = 1'b1;
          cmd_o.v_mix = pass_q;
          cmd_o.s_k   = kprev;
          if (!pass_q) begin
            cmd_o.v_we  = 1'b1;
            cmd_o.v_off = {sub_q, kprev};
          end
        end
        if (cnt_q == 7'd8) begin
          state_d = ST_SALSA;
          cnt_d   = '0;
        end else begin
          cnt_d = 7'(cnt_q + 7'd1);
        end
      end
      ST_SALSA: begin
        cmd_o.sal_init = (cnt_q == 7'd0);
        cmd_o.sal_rnd  = (cnt_q != 7'd0) && (cnt_q < 7'd9);
        cmd_o.sal_odd  = !cnt_q[0];
        cmd_o.sal_fin  = (cnt_q == 7'd9);
        if (cnt_q == 7'd9) begin
          state_d = ST_WR;
          cnt_d   = '0;
        end else begin
          cnt_d = 7'(cnt_q + 7'd1);
        end
      end
      ST_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_other = 1'b1;
        cmd_o.wr_idx   = {pos, cnt_q[2:0]};
        cnt_d          = 7'(cnt_q + 7'd1);
        if (cnt_q == 7'd7) begin
          cnt_d = '0;
          if (sub_q == last_sub) begin
            cmd_o.swap = 1'b1;
            if (round_q == NW'(n_i - NW'(1))) begin
              round_d = '0;
              if (!pass_q) begin
                pass_d  = 1'b1;
                state_d = ST_JRD;
              end else begin
                state_d = ST_EMIT;
              end
            end else begin
              round_d = NW'(round_q + NW'(1));
              state_d = pass_q ? ST_JRD : ST_INIT;
            end
          end else begin
            sub_d   = 3'(sub_q + 3'd1);
            state_d = ST_SUBRD;
          end
        end
      end
      ST_JRD: begin
        if (cnt_q == 7'd0) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = {last_sub, 3'd0};
          cnt_d        = 7'd1;
        end else begin
          cmd_o.mod_ld = 1'b1;
          cnt_d        = '0;
          state_d      = ST_MOD;
        end
      end
      ST_MOD: begin
        if (cnt_q == 7'd32) begin
          cmd_o.base_ld  = 1'b1;
          cmd_o.base_mod = 1'b1;
          cnt_d          = '0;
          state_d        = ST_INIT;
        end else begin
          cmd_o.mod_step = 1'b1;
          cnt_d          = 7'(cnt_q + 7'd1);
        end
      end
      ST_EMIT: begin
        if (cnt_q == items) begin
          cnt_d   = '0;
          state_d = ST_LOAD;
        end else if (stat_i.emit_ok) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_idx   = cnt_q[5:0];
          cmd_o.em_issue = 1'b1;
          cmd_o.em_last  = (7'(cnt_q + 7'd1) == items);
          cnt_d          = 7'(cnt_q + 7'd1);
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
    if (cfg_clr_i) begin
      load_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      sub_q   <= '0;
      round_q <= '0;
      pass_q  <= 1'b0;
      load_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sub_q   <= sub_d;
      round_q <= round_d;
      pass_q  <= pass_d;
      load_q  <= load_d;
    end
  end

endmodule

// File: src/scr_dp.sv
module scr_dp import scr_pkg::*; #(
  parameter int N_MAX = N_MAX_DEF,
  parameter int R_MAX = R_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  input  logic [$clog2(N_MAX+1)-1:0]   round_i,
  input  logic [R_W-1:0]               r_i,
  input  logic [$clog2(N_MAX+1)-1:0]   n_i,
  input  logic [63:0]                  in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [63:0]                  out_data_o,
  output logic                         out_last_o,
  output stat_t                        stat_o
);

  localparam int NW    = $clog2(N_MAX + 1);
  localparam int ITEMS = 16 * R_MAX;
  localparam int IW    = $clog2(ITEMS);
  localparam int VD    = N_MAX * ITEMS;
  localparam int VAW   = $clog2(VD);

  logic [63:0] bufm [2*ITEMS];
  logic [63:0] vm [VD];

  logic          cur_q;
  logic [63:0]   buf_rd_q;
  logic [63:0]   v_rd_q;
  sstate_t       s_q;
  sstate_t       w_q;
  logic [VAW-1:0] base_q;
  logic [31:0]   x_q;
  logic [NW-1:0] rem_q;
  logic          infl_q, infl_last_q;
  logic          outv_q, skv_q;
  logic [63:0]   out_data_q, skid_data_q;
  logic          out_last_q, skid_last_q;

  logic [IW:0]    buf_raddr, buf_waddr;
  logic [63:0]    buf_wdata;
  logic [VAW-1:0] v_addr;
  logic [63:0]    src_item;
  logic [NW+2:0]  prod;
  logic [NW+6:0]  base_full;
  logic [NW:0]    rem_t, n_x;
  logic           pop;
  logic [1:0]     occ;

  assign buf_raddr = {cur_q, cmd_i.rd_idx[IW-1:0]};
  assign buf_waddr = {cur_q ^ cmd_i.wr_other, cmd_i.wr_idx[IW-1:0]};
  assign buf_wdata = cmd_i.wr_in ? in_data_i
                   : {s_q[{cmd_i.wr_idx[2:0], 1'b1}], s_q[{cmd_i.wr_idx[2:0], 1'b0}]};
  assign v_addr    = VAW'(base_q + {{(VAW-IW){1'b0}}, cmd_i.v_off[IW-1:0]});
  assign src_item  = buf_rd_q ^ (cmd_i.v_mix ? v_rd_q : 64'd0);
  assign prod      = (cmd_i.base_mod ? rem_q : round_i) * r_i;
  assign base_full = {prod, 4'b0000};
  assign rem_t     = {rem_q, x_q[31]};
  assign n_x       = {1'b0, n_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      bufm[buf_waddr] <= buf_wdata;
    end
    if (cmd_i.rd_en) begin
      buf_rd_q <= bufm[buf_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.v_we) begin
      vm[v_addr] <= buf_rd_q;
    end
    if (cmd_i.v_re) begin
      v_rd_q <= vm[v_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.s_ld) begin
      if (cmd_i.s_xor) begin
        s_q[{cmd_i.s_k, 1'b0}] <= s_q[{cmd_i.s_k, 1'b0}] ^ src_item[31:0];
        s_q[{cmd_i.s_k, 1'b1}] <= s_q[{cmd_i.s_k, 1'b1}] ^ src_item[63:32];
      end else begin
        s_q[{cmd_i.s_k, 1'b0}] <= src_item[31:0];
        s_q[{cmd_i.s_k, 1'b1}] <= src_item[63:32];
      end
    end else if (cmd_i.sal_fin) begin
      for (int k = 0; k < 16; k++) begin
        s_q[k] <= s_q[k] + w_q[k];
      end
    end
    if (cmd_i.sal_init) begin
      w_q <= s_q;
    end else if (cmd_i.sal_rnd) begin
      w_q <= half_round(w_q, cmd_i.sal_odd);
    end
    if (cmd_i.base_ld) begin
      base_q <= base_full[VAW-1:0];
    end
    if (cmd_i.mod_ld) begin
      x_q   <= buf_rd_q[31:0];
      rem_q <= '0;
    end else if (cmd_i.mod_step) begin
      x_q   <= {x_q[30:0], 1'b0};
      rem_q <= (rem_t >= n_x) ? NW'(rem_t - n_x) : rem_t[NW-1:0];
    end
  end

  // output register plus skid stage, fed by the buffer read port
  assign pop    = outv_q && !out_stall_i;
  assign occ    = 2'(outv_q) + 2'(skv_q) + 2'(infl_q);
  assign stat_o = '{emit_ok:   (2'(occ - 2'(pop)) < 2'd2),
                    out_full:  outv_q,
                    skid_full: skv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= 1'b0;
      infl_q <= 1'b0;
      outv_q <= 1'b0;
      skv_q  <= 1'b0;
    end else begin
      if (cmd_i.swap) begin
        cur_q <= !cur_q;
      end
      infl_q      <= cmd_i.em_issue;
      infl_last_q <= cmd_i.em_last;
      if (pop) begin
        if (skv_q) begin
          out_data_q  <= skid_data_q;
          out_last_q  <= skid_last_q;
          skv_q       <= infl_q;
          skid_data_q <= buf_rd_q;
          skid_last_q <= infl_last_q;
        end else begin
          outv_q     <= infl_q;
          out_data_q <= buf_rd_q;
          out_last_q <= infl_last_q;
        end
      end else if (infl_q) begin
        if (!outv_q) begin
          outv_q     <= 1'b1;
          out_data_q <= buf_rd_q;
          out_last_q <= infl_last_q;
        end else begin
          skv_q       <= 1'b1;
          skid_data_q <= buf_rd_q;
          skid_last_q <= infl_last_q;
        end
      end
    end
  end

  assign out_valid_o = outv_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule
